[rtl/core/u8d_pkg.sv]
`timescale 1ns / 1ps

package u8d_pkg;

	localparam int unsigned CP_W       = 21;
	localparam int unsigned JOB_DEPTH  = 4;
	localparam int unsigned JOB_PTR_W  = $clog2(JOB_DEPTH);
	localparam int unsigned JOB_CNT_W  = $clog2(JOB_DEPTH + 1);

	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_2B     = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3B     = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4B     = 21'h010000;

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE  = 2'd1;
	localparam logic [1:0] NEED_TWO  = 2'd2;
	localparam logic [1:0] NEED_THREE = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic            was_replaced;
		logic            last_of_run;
		logic            text_done;
	} result_t;

	// one byte's worth of output: n_rep replacements, then optionally val
	typedef struct packed {
		logic [2:0]      n_rep;
		logic            has_val;
		logic [CP_W-1:0] val;
		logic            eot;
	} job_t;

endpackage

[rtl/core/u8d_front.sv]
`timescale 1ns / 1ps

module u8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8d_pkg::byte_item_t byte_item,
	input  logic                q_full,
	output logic                full,
	output logic                job_push,
	output u8d_pkg::job_t       job
);
	import u8d_pkg::*;

	logic [1:0]      need_q, need_d;
	logic [1:0]      seen_q, seen_d;
	logic [CP_W-1:0] part_q, part_d;

	logic [7:0]      b;
	logic            eot;
	logic            accept;
	logic            pending;
	logic            is_cont;
	logic            l_ascii;
	logic [1:0]      l_need;
	logic [CP_W-1:0] l_val;
	logic [CP_W-1:0] cont_part;
	logic [1:0]      cont_seen;
	logic            complete;
	logic [CP_W-1:0] min_v;
	logic            range_bad;
	logic            do_lead;
	logic [2:0]      n_rep;
	logic            has_val;
	logic [CP_W-1:0] val;

	assign b       = byte_item.text_byte;
	assign eot     = byte_item.end_of_text;
	assign full    = q_full;
	assign accept  = push & ~q_full;
	assign pending = (need_q != NEED_NONE);
	assign is_cont = ((b & CONT_MASK) == CONT_TAG);

	always_comb begin
		l_ascii = ~b[7];
		l_need  = NEED_NONE;
		l_val   = '0;
		priority if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			l_need = NEED_ONE;
			l_val  = {16'd0, b[4:0]};
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			l_need = NEED_TWO;
			l_val  = {17'd0, b[3:0]};
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			l_need = NEED_THREE;
			l_val  = {18'd0, b[2:0]};
		end else begin
			l_need = NEED_NONE;
		end
	end

	assign cont_part = {part_q[CP_W-7:0], b[5:0]};
	assign cont_seen = seen_q + 2'd1;
	assign complete  = (cont_seen >= need_q);

	always_comb begin
		unique case (need_q)
			NEED_TWO:   min_v = MIN_3B;
			NEED_THREE: min_v = MIN_4B;
			default:    min_v = MIN_2B;
		endcase
	end

	assign range_bad = (cont_part < min_v) || (cont_part > MAX_CP) ||
		(cont_part >= SURR_LO && cont_part <= SURR_HI);

	always_comb begin
		n_rep   = 3'd0;
		has_val = 1'b0;
		val     = '0;
		need_d  = need_q;
		seen_d  = seen_q;
		part_d  = part_q;
		do_lead = 1'b0;
		if (!pending) begin
			do_lead = 1'b1;
		end else if (is_cont) begin
			part_d = cont_part;
			seen_d = cont_seen;
			if (complete) begin
				if (range_bad) begin
					n_rep = {1'b0, cont_seen} + 3'd1;
				end else begin
					has_val = 1'b1;
					val     = cont_part;
				end
				need_d = NEED_NONE;
				seen_d = 2'd0;
				part_d = '0;
			end else if (eot) begin
				n_rep  = {1'b0, cont_seen} + 3'd1;
				need_d = NEED_NONE;
				seen_d = 2'd0;
				part_d = '0;
			end
		end else begin
			// breaking byte: flush lead and held continuations, then redo as lead
			n_rep   = {1'b0, seen_q} + 3'd1;
			need_d  = NEED_NONE;
			seen_d  = 2'd0;
			part_d  = '0;
			do_lead = 1'b1;
		end

		if (do_lead) begin
			if (l_ascii) begin
				has_val = 1'b1;
				val     = {13'd0, b};
			end else if (l_need == NEED_NONE || eot) begin
				n_rep = n_rep + 3'd1;
			end else begin
				need_d = l_need;
				seen_d = 2'd0;
				part_d = l_val;
			end
		end
	end

	assign job_push    = accept & ((n_rep != 3'd0) | has_val);
	assign job.n_rep   = n_rep;
	assign job.has_val = has_val;
	assign job.val     = val;
	assign job.eot     = eot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= NEED_NONE;
			seen_q <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			need_q <= need_d;
			seen_q <= seen_d;
			part_q <= part_d;
		end
	end

endmodule

[rtl/core/u8d_jobq.sv]
`timescale 1ns / 1ps

module u8d_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u8d_pkg::job_t din,
	input  logic          pop,
	output u8d_pkg::job_t dout,
	output logic          full,
	output logic          empty
);
	import u8d_pkg::*;

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + JOB_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - JOB_CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/u8d_back.sv]
`timescale 1ns / 1ps

module u8d_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  u8d_pkg::job_t                job,
	input  logic [u8d_pkg::CP_W-1:0]     repl,
	output logic                         job_pop,
	input  logic                         pop,
	output logic                         empty,
	output u8d_pkg::result_t             result
);
	import u8d_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	result_t    result_q;
	logic [2:0] total;
	logic       is_rep;
	logic       last;
	logic       advance;
	result_t    item;

	assign total   = job.n_rep + {2'd0, job.has_val};
	assign is_rep  = (idx_q < job.n_rep);
	assign last    = (idx_q == total - 3'd1);
	assign advance = ~out_valid_q | pop;
	assign job_pop = advance & job_valid & last;

	// replacements come first, the decoded value (if any) closes the run
	assign item.codepoint    = is_rep ? repl : job.val;
	assign item.was_replaced = is_rep;
	assign item.last_of_run  = last;
	assign item.text_done    = last & job.eot;

	assign empty  = ~out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (advance && job_valid) begin
			result_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= job_valid;
			if (job_valid) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

[rtl/core/utf8_stream_decoder.sv]
`timescale 1ns / 1ps

// channel    | handshake             | payload
// -----------+-----------------------+-------------------------------------
// byte in    | push / full           | byte_item  (text_byte, end_of_text)
// result out | pop / empty           | result     (codepoint, was_replaced,
//            |                       |             last_of_run, text_done)
// config     | cfg_valid / cfg_ready | cfg_data   (replacement code point)
//
// One byte is taken per cycle while full is low; a byte that yields k code
// points (at most four) holds the result side until all k are out, one
// result per cycle while pop is held high. A four-entry job queue between
// the byte classifier and the result sequencer absorbs those runs; full
// rises only when that queue is full. A byte's job is queued, and its
// first result is then registered before it reaches the ports.
// cfg_ready is always high. Reset clears the pending sequence, the queue
// and the output valid flag, and sets the replacement code point to U+FFFD.

module utf8_stream_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  u8d_pkg::byte_item_t          byte_item,
	input  logic                         pop,
	output logic                         empty,
	output u8d_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [u8d_pkg::CP_W-1:0]     cfg_data
);
	import u8d_pkg::*;

	logic [CP_W-1:0] repl_q;
	logic            job_push;
	job_t            job_in;
	job_t            job_out;
	logic            q_full;
	logic            q_empty;
	logic            job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.byte_item (byte_item),
		.q_full    (q_full),
		.full      (full),
		.job_push  (job_push),
		.job       (job_in)
	);

	u8d_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (~q_empty),
		.job       (job_out),
		.repl      (repl_q),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.text_done) |-> result.last_of_run)
		else $error("text_done without last_of_run");

	a_decoded_is_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.was_replaced) |->
		((result.codepoint <= MAX_CP) &&
		 ((result.codepoint < SURR_LO) || (result.codepoint > SURR_HI))))
		else $error("decoded value is not a Unicode scalar");

	a_only_repl_before_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last_of_run) |-> result.was_replaced)
		else $error("decoded value inside a run");

endmodule

[bench/utf8_stream_decoder_tb.sv]
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
	import u8d_pkg::*;

	typedef enum logic [1:0] {ST_BYTE, ST_CFG, ST_DRAIN} stim_kind_t;

	typedef struct {
		stim_kind_t      kind;
		byte_item_t      item;
		logic [CP_W-1:0] cfg;
	} stim_t;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int DIRECTED_LEN  = 28;
	localparam int PHASE_BYTES   = 96;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            push      = 1'b0;
	logic            full;
	byte_item_t      byte_item = '0;
	logic            pop       = 1'b0;
	logic            empty;
	result_t         result;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CP_W-1:0] cfg_data  = '0;

	// handshake flags captured at the rising edge, consumed at the falling edge
	logic byte_taken = 1'b0;
	logic cp_taken   = 1'b0;
	logic cfg_taken  = 1'b0;

	stim_t   pending_q[$];
	result_t codepoints_due[$];
	result_t step_out[$];

	// decoder state mirror
	logic [1:0]      seq_need = NEED_NONE;
	logic [1:0]      seq_seen = '0;
	logic [CP_W-1:0] seq_val  = '0;
	logic [CP_W-1:0] repl_cp  = REPL_RESET;

	int bytes_queued = 0;
	int bytes_fed    = 0;
	int cps_checked  = 0;
	int cfg_writes   = 0;
	int err_cnt      = 0;
	int idle_cycles  = 0;
	int settle_cnt   = 0;
	int tx_gap       = 0;
	int tx_run       = 0;
	int rx_gap       = 0;
	int rx_run       = 0;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_item(byte_item),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------- decoder prediction ----------------

	function automatic void put_cp(input logic [CP_W-1:0] cp, input logic bad);
		step_out.push_back({cp, bad, 2'b00});
	endfunction

	function automatic void close_seq();
		seq_need = NEED_NONE;
		seq_seen = '0;
		seq_val  = '0;
	endfunction

	// lead byte gets one replacement, each held continuation one more
	function automatic void abandon_seq(input logic [1:0] held);
		put_cp(repl_cp, 1'b1);
		for (int i = 0; i < held; i++)
			put_cp(repl_cp, 1'b1);
		close_seq();
	endfunction

	function automatic void start_seq(input logic [7:0] b, input logic eot);
		logic [1:0]      need;
		logic [CP_W-1:0] val;
		if (!b[7]) begin
			put_cp(CP_W'(b), 1'b0);
			return;
		end
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			need = NEED_ONE;
			val  = CP_W'(b[4:0]);
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			need = NEED_TWO;
			val  = CP_W'(b[3:0]);
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			need = NEED_THREE;
			val  = CP_W'(b[2:0]);
		end else begin
			put_cp(repl_cp, 1'b1);
			return;
		end
		if (eot) begin
			put_cp(repl_cp, 1'b1);
			return;
		end
		seq_need = need;
		seq_seen = '0;
		seq_val  = val;
	endfunction

	function automatic void decode_byte(input byte_item_t it);
		logic [CP_W-1:0] floor_cp;
		int              last;
		step_out.delete();
		if (seq_need == NEED_NONE) begin
			start_seq(it.text_byte, it.end_of_text);
		end else if ((it.text_byte & CONT_MASK) == CONT_TAG) begin
			seq_val  = {seq_val[CP_W-7:0], it.text_byte[5:0]};
			seq_seen = seq_seen + 2'd1;
			if (seq_seen >= seq_need) begin
				floor_cp = (seq_need == NEED_ONE) ? MIN_2B :
					(seq_need == NEED_TWO) ? MIN_3B : MIN_4B;
				if (seq_val < floor_cp || seq_val > MAX_CP ||
					(seq_val >= SURR_LO && seq_val <= SURR_HI)) begin
					abandon_seq(seq_seen);
				end else begin
					put_cp(seq_val, 1'b0);
					close_seq();
				end
			end else if (it.end_of_text) begin
				abandon_seq(seq_seen);
			end
		end else begin
			// breaking byte: flush the open sequence, then retry it as a lead
			abandon_seq(seq_seen);
			start_seq(it.text_byte, it.end_of_text);
		end
		if (step_out.size() != 0) begin
			last = step_out.size() - 1;
			step_out[last].last_of_run = 1'b1;
			step_out[last].text_done   = it.end_of_text;
		end
		foreach (step_out[i])
			codepoints_due.push_back(step_out[i]);
	endfunction

	// ---------------- stimulus building ----------------

	function automatic void add_stim(input stim_kind_t kind, input logic [7:0] b,
		input logic eot, input logic [CP_W-1:0] v);
		stim_t s;
		s.kind = kind;
		s.item = {b, eot};
		s.cfg  = v;
		pending_q.push_back(s);
		if (kind == ST_BYTE)
			bytes_queued++;
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic eot);
		add_stim(ST_BYTE, b, eot, '0);
	endfunction

	// encode cp in len bytes, send the first keep of them; bad_at > 0 corrupts that byte
	function automatic void add_seq(input logic [CP_W-1:0] cp, input int len, input int keep,
		input int bad_at, input logic eot);
		logic [7:0] b;
		for (int i = 0; i < keep; i++) begin
			if (i == 0) begin
				case (len)
					1: b = {1'b0, cp[6:0]};
					2: b = {3'b110, cp[10:6]};
					3: b = {4'b1110, cp[15:12]};
					default: b = {5'b11110, cp[20:18]};
				endcase
			end else begin
				b = {2'b10, 6'(cp >> (6 * (len - 1 - i)))};
			end
			if (bad_at > 0 && i == bad_at)
				b = 8'($urandom_range(0, 255));
			add_byte(b, eot && (i == keep - 1));
		end
	endfunction

	function automatic logic [CP_W-1:0] rand_cp(input int len);
		case (len)
			1: return CP_W'($urandom_range(0, 'h7F));
			2: return CP_W'($urandom_range('h80, 'h7FF));
			3: return CP_W'($urandom_range('h800, 'hFFFF));
			default: return CP_W'($urandom_range('h10000, 'h11FFFF));
		endcase
	endfunction

	function automatic void add_random_unit();
		int   pick;
		int   len;
		logic eot;
		pick = $urandom_range(0, 99);
		len  = $urandom_range(2, 4);
		eot  = ($urandom_range(0, 11) == 0);
		if (pick < 55) begin
			len = $urandom_range(1, 4);
			add_seq(rand_cp(len), len, len, 0, eot);
		end else if (pick < 63) begin
			// overlong: value fits in a shorter form
			add_seq(rand_cp(len - 1), len, len, 0, eot);
		end else if (pick < 68) begin
			add_seq(CP_W'($urandom_range(SURR_LO, SURR_HI)), 3, 3, 0, eot);
		end else if (pick < 78) begin
			add_seq(rand_cp(len), len, $urandom_range(1, len - 1), 0, eot);
		end else if (pick < 88) begin
			add_seq(rand_cp(len), len, len, $urandom_range(1, len - 1), eot);
		end else begin
			add_byte(8'($urandom_range(0, 255)), eot);
		end
		if ($urandom_range(0, 59) == 0)
			add_stim(ST_DRAIN, '0, 1'b0, '0);
	endfunction

	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			run_left = $urandom_range(10, 40);
		return $urandom_range(0, 9);
	endfunction

	function automatic void check_field(input string name, input logic [CP_W-1:0] want,
		input logic [CP_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			err_cnt++;
		end
	endfunction

	// ---------------- sender ----------------

	always @(negedge clk) begin
		logic nxt_push;
		logic nxt_cfg;
		nxt_push = push && !byte_taken;
		nxt_cfg  = cfg_valid && !cfg_taken;
		if (arst_n && !nxt_push && !nxt_cfg) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_q.size() != 0) begin
				case (pending_q[0].kind)
					ST_BYTE: begin
						byte_item <= pending_q[0].item;
						nxt_push = 1'b1;
						pending_q.pop_front();
						tx_gap = draw_gap(tx_run);
					end
					ST_CFG: begin
						if (settle_cnt >= SETTLE_CYCLES) begin
							cfg_data <= pending_q[0].cfg;
							nxt_cfg = 1'b1;
							pending_q.pop_front();
						end
					end
					default: begin
						if (codepoints_due.size() == 0)
							pending_q.pop_front();
					end
				endcase
			end
		end
		push      <= nxt_push;
		cfg_valid <= nxt_cfg;
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (pop && cp_taken)
				rx_gap = draw_gap(rx_run);
			else if (!pop && rx_gap > 0)
				rx_gap--;
			pop <= (rx_gap == 0);
		end
	end

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			byte_taken <= push && !full;
			cp_taken   <= pop && !empty;
			cfg_taken  <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				repl_cp = cfg_data;
				cfg_writes++;
			end
			if (push && !full) begin
				decode_byte(byte_item);
				bytes_fed++;
			end
			if (pop && !empty) begin
				if (codepoints_due.size() == 0) begin
					$error("unexpected transaction: codepoint %h", result.codepoint);
					err_cnt++;
				end else begin
					want = codepoints_due.pop_front();
					check_field("codepoint", want.codepoint, result.codepoint);
					check_field("was_replaced", CP_W'(want.was_replaced),
						CP_W'(result.was_replaced));
					check_field("last_of_run", CP_W'(want.last_of_run),
						CP_W'(result.last_of_run));
					check_field("text_done", CP_W'(want.text_done),
						CP_W'(result.text_done));
				end
				cps_checked++;
			end
			if ((push && !full) || codepoints_due.size() != 0)
				settle_cnt = 0;
			else if (settle_cnt < SETTLE_CYCLES)
				settle_cnt++;
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d code points outstanding",
					IDLE_LIMIT, codepoints_due.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		logic [CP_W-1:0] repl_val;
		// directed: field extremes and each error path, default replacement value
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b1);
		add_seq('h80, 2, 2, 0, 1'b0);
		add_seq('h7FF, 2, 2, 0, 1'b0);
		add_seq('hD800, 3, 3, 0, 1'b0);         // surrogate
		add_seq('h10FFFF, 4, 4, 0, 1'b0);
		add_seq('h110000, 4, 4, 0, 1'b0);       // above the code space
		add_seq('h7F, 3, 3, 0, 1'b0);           // overlong
		add_byte(8'hC1, 1'b0);                  // invalid leads
		add_byte(8'hFF, 1'b0);
		add_seq('h20AC, 3, 2, 0, 1'b0);         // cut short by an ASCII byte
		add_byte(8'h41, 1'b0);
		add_byte(8'hF0, 1'b0);                  // open sequence at end of text
		add_byte(8'h90, 1'b1);
		add_byte(8'hC3, 1'b1);                  // lead as the final byte
		add_stim(ST_DRAIN, '0, 1'b0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: repl_val = MAX_CP;
				1: repl_val = '0;
				2: repl_val = CP_W'($urandom_range(0, MAX_CP));
				default: repl_val = REPL_RESET;
			endcase
			add_stim(ST_CFG, '0, 1'b0, repl_val);
			while (bytes_queued < DIRECTED_LEN + (ph + 1) * PHASE_BYTES)
				add_random_unit();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || push || cfg_valid)
			@(posedge clk);
		while (codepoints_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("fed %0d bytes, checked %0d code points, %0d replacement-value writes",
			bytes_fed, cps_checked, cfg_writes);
		$display("mix: valid 1-4 byte forms, overlong, surrogate, out of range, truncated,");
		$display("corrupted and stray bytes, end of text mid-sequence, random stalls");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_jobq.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
